// ===== sv/ble_pkg.sv =====
package ble_pkg;

    localparam int IN_MV_W    = 12;
    localparam int SCALE_W    = 8;
    localparam int AVG_W      = 16;
    localparam int TENTHS_W   = 10;
    localparam int CNT_CFG_W  = 8;
    localparam int SUM_W      = 24;
    localparam int PCT_W      = 7;
    localparam int POINT_W    = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = POINT_W;
    localparam int SCALE_SHIFT = 6;

    localparam int NUM_POINT_REGS   = 6;
    localparam int CURVE_POINTS_DEF = 6;

    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = 16;

    localparam logic [AVG_W-1:0]    EMPTY_MARK = 16'hFFFF;
    localparam logic [TENTHS_W-1:0] MAX_TENTHS = 10'd1000;
    localparam int                  TENTHS     = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT0  = 3'd2;

    localparam logic [CNT_CFG_W-1:0] SAMPLES_RESET = 8'd8;
    localparam logic [CNT_CFG_W-1:0] DIVISOR_RESET = 8'd4;

    typedef logic [POINT_W-1:0] point_t;
    typedef point_t point_arr_t [NUM_POINT_REGS];

    localparam point_arr_t POINT_RESET = '{
        23'd3300, 23'd658960, 23'd2625190, 23'd4591420, 23'd5902290, 23'd6557800
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_AVG,
        ST_STEP_WAIT,
        ST_LEVEL,
        ST_SEG,
        ST_LEVEL_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accum;
        logic mean_start;
        logic mean_latch;
        logic seed;
        logic step_start;
        logic step_apply;
        logic seg_latch;
        logic level_edge;
        logic level_start;
        logic level_latch;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last_sample;
        logic avg_empty;
        logic div_done;
        logic seg_edge;
        logic out_free;
    } status_t;

endpackage

// ===== sv/ble_in_if.sv =====
interface ble_in_if
    import ble_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [IN_MV_W-1:0]   sample_millivolts;
    logic [SCALE_W-1:0]   mode_scale;

    modport source (output valid, output sample_millivolts, output mode_scale, input ready);
    modport sink   (input valid, input sample_millivolts, input mode_scale, output ready);
endinterface

// ===== sv/ble_out_if.sv =====
interface ble_out_if
    import ble_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [AVG_W-1:0]     average_millivolts;
    logic [TENTHS_W-1:0]  charge_tenths;

    modport source (output valid, output average_millivolts, output charge_tenths, input ready);
    modport sink   (input valid, input average_millivolts, input charge_tenths, output ready);
endinterface

// ===== sv/ble_div.sv =====
module ble_div
    import ble_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);
    localparam int STEP_CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0]  quo_reg, quo_next;
    logic [DIV_DEN_W-1:0]  rem_reg, rem_next;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIV_DEN_W:0]    shifted;
    logic [DIV_DEN_W:0]    trial;
    logic                  fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = STEP_CNT_W'(DIV_NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[DIV_NUM_W-2:0], fits};
            rem_next  = fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/ble_datapath.sv =====
module ble_datapath
    import ble_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               sts,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic [IN_MV_W-1:0]    sample_millivolts,
    input  logic [SCALE_W-1:0]    mode_scale,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [AVG_W-1:0]      average_millivolts,
    output logic [TENTHS_W-1:0]   charge_tenths
);
    localparam int NPTS = (CURVE_POINTS > NUM_POINT_REGS) ? NUM_POINT_REGS : CURVE_POINTS;
    localparam int PROD_W = IN_MV_W + SCALE_W;
    localparam int DIFF_W = SUM_W + 1;
    localparam int TERM_W = AVG_W + PCT_W;
    localparam int EDGE_W = PCT_W + 4;

    logic [CNT_CFG_W-1:0] spr_reg, adiv_reg;
    point_arr_t           point_reg;

    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_CFG_W-1:0] taken_reg;
    logic [AVG_W-1:0]     avg_reg;
    logic [SUM_W-1:0]     mean_reg;
    logic                 diff_neg_reg;
    logic                 seg_edge_reg;
    logic [PCT_W-1:0]     edge_pct_reg, lo_pct_reg, hi_pct_reg;
    logic [AVG_W-1:0]     a_reg, b_reg, den_reg;
    logic [TENTHS_W-1:0]  level_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]     out_avg_reg;
    logic [TENTHS_W-1:0]  out_level_reg;

    logic [CNT_CFG_W-1:0] count_eff, divv_eff, taken_inc;
    logic [PROD_W-1:0]    prod;
    logic [SUM_W-1:0]     scaled;
    logic [DIFF_W-1:0]    diff_w, diff_mag;
    logic                 seg_found, seg_first;
    point_t               lo_pt, hi_pt;
    logic [TERM_W-1:0]    term_hi, term_lo;
    logic [SUM_W-1:0]     term_sum;
    logic [DIV_NUM_W-1:0] level_num;
    logic [EDGE_W-1:0]    edge_tenths;

    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_dividend, div_quotient;
    logic [DIV_DEN_W-1:0] div_divisor;

    assign count_eff = (spr_reg == '0) ? CNT_CFG_W'(1) : spr_reg;
    assign divv_eff  = (adiv_reg == '0) ? CNT_CFG_W'(1) : adiv_reg;
    assign taken_inc = taken_reg + 1'b1;
    assign prod      = PROD_W'(sample_millivolts) * PROD_W'(mode_scale);
    assign scaled    = SUM_W'(prod >> SCALE_SHIFT);

    assign diff_w   = {1'b0, mean_reg} - DIFF_W'(avg_reg);
    assign diff_mag = diff_w[DIFF_W-1] ? (~diff_w + 1'b1) : diff_w;

    // first point at or above the average
    always_comb
    begin
        seg_found = 1'b0;
        seg_first = 1'b0;
        hi_pt     = point_reg[0];
        lo_pt     = point_reg[0];
        for (int i = NPTS - 1; i >= 0; i--)
        begin
            if (point_reg[i][AVG_W-1:0] >= avg_reg)
            begin
                seg_found = 1'b1;
                seg_first = (i == 0);
                hi_pt     = point_reg[i];
                lo_pt     = point_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    assign term_hi     = TERM_W'(a_reg) * TERM_W'(hi_pct_reg);
    assign term_lo     = TERM_W'(b_reg) * TERM_W'(lo_pct_reg);
    assign term_sum    = SUM_W'(term_hi) + SUM_W'(term_lo);
    assign level_num   = DIV_NUM_W'(term_sum) * DIV_NUM_W'(TENTHS);
    assign edge_tenths = EDGE_W'(edge_pct_reg) * EDGE_W'(TENTHS);

    always_comb
    begin
        div_start    = cmd.mean_start | cmd.step_start | cmd.level_start;
        div_dividend = level_num;
        div_divisor  = den_reg;
        if (cmd.mean_start)
        begin
            div_dividend = DIV_NUM_W'(sum_reg);
            div_divisor  = DIV_DEN_W'(count_eff);
        end
        else if (cmd.step_start)
        begin
            div_dividend = DIV_NUM_W'(diff_mag);
            div_divisor  = DIV_DEN_W'(divv_eff);
        end
    end

    ble_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg   <= SAMPLES_RESET;
            adiv_reg  <= DIVISOR_RESET;
            point_reg <= POINT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SAMPLES: spr_reg  <= wr_data[CNT_CFG_W-1:0];
                REG_DIVISOR: adiv_reg <= wr_data[CNT_CFG_W-1:0];
                default:     point_reg[wr_index - REG_POINT0] <= wr_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            taken_reg     <= '0;
            avg_reg       <= EMPTY_MARK;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.accum)
            begin
                sum_reg   <= sum_reg + scaled;
                taken_reg <= taken_inc;
            end
            else if (cmd.mean_start)
            begin
                sum_reg   <= '0;
                taken_reg <= '0;
            end
            if (cmd.seed)
            begin
                avg_reg <= mean_reg[AVG_W-1:0];
            end
            else if (cmd.step_apply)
            begin
                avg_reg <= diff_neg_reg ? avg_reg - div_quotient[AVG_W-1:0]
                                        : avg_reg + div_quotient[AVG_W-1:0];
            end
            if (cmd.level_edge)
            begin
                level_reg <= (edge_tenths > EDGE_W'(MAX_TENTHS)) ? MAX_TENTHS
                                                                 : edge_tenths[TENTHS_W-1:0];
            end
            else if (cmd.level_latch)
            begin
                level_reg <= (div_quotient > DIV_NUM_W'(MAX_TENTHS)) ? MAX_TENTHS
                                                                     : div_quotient[TENTHS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mean_latch)
        begin
            mean_reg <= div_quotient[SUM_W-1:0];
        end
        if (cmd.step_start)
        begin
            diff_neg_reg <= diff_w[DIFF_W-1];
        end
        if (cmd.seg_latch)
        begin
            seg_edge_reg <= !seg_found || seg_first;
            edge_pct_reg <= seg_found ? point_reg[0][POINT_W-1:AVG_W]
                                      : point_reg[NPTS-1][POINT_W-1:AVG_W];
            lo_pct_reg   <= lo_pt[POINT_W-1:AVG_W];
            hi_pct_reg   <= hi_pt[POINT_W-1:AVG_W];
            a_reg        <= avg_reg - lo_pt[AVG_W-1:0];
            b_reg        <= hi_pt[AVG_W-1:0] - avg_reg;
            den_reg      <= hi_pt[AVG_W-1:0] - lo_pt[AVG_W-1:0];
        end
        if (cmd.emit)
        begin
            out_avg_reg   <= avg_reg;
            out_level_reg <= level_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        sts.last_sample = taken_inc >= count_eff;
        sts.avg_empty   = avg_reg == EMPTY_MARK;
        sts.div_done    = div_done;
        sts.seg_edge    = seg_edge_reg;
        sts.out_free    = !out_valid_reg || result_ready;
    end

    assign result_valid       = out_valid_reg;
    assign average_millivolts = out_avg_reg;
    assign charge_tenths      = out_level_reg;

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= MAX_TENTHS)
        else $error("charge level above full scale");

    a_reading_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mean_start |=> (taken_reg == '0) && (sum_reg == '0))
        else $error("sample sum not cleared after a reading");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg && (out_avg_reg == $past(avg_reg)))
        else $error("result not presented after emit");
`endif

endmodule

// ===== sv/ble_ctrl.sv =====
module ble_ctrl
    import ble_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t sts,
    output cmd_t    cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.last_sample)
                begin
                    state_next = ST_MEAN_START;
                end
            end
            ST_MEAN_START: state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: state_next = sts.avg_empty ? ST_LEVEL : ST_STEP_WAIT;
            ST_STEP_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL: state_next = ST_SEG;
            ST_SEG: state_next = sts.seg_edge ? ST_EMIT : ST_LEVEL_WAIT;
            ST_LEVEL_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.accum = in_valid;
            end
            ST_MEAN_START: cmd.mean_start = 1'b1;
            ST_MEAN_WAIT:  cmd.mean_latch = sts.div_done;
            ST_AVG:
            begin
                cmd.seed       = sts.avg_empty;
                cmd.step_start = !sts.avg_empty;
            end
            ST_STEP_WAIT:  cmd.step_apply = sts.div_done;
            ST_LEVEL:      cmd.seg_latch  = 1'b1;
            ST_SEG:
            begin
                cmd.level_edge  = sts.seg_edge;
                cmd.level_start = !sts.seg_edge;
            end
            ST_LEVEL_WAIT: cmd.level_latch = sts.div_done;
            ST_EMIT:       cmd.emit        = sts.out_free;
            default:       cmd = '0;
        endcase
    end

endmodule

// ===== sv/battery_level_estimator.sv =====
// channel     dir  payload                                 handshake
// sample_in   in   sample_millivolts[11:0], mode_scale[7:0] valid/ready
// result_out  out  average_millivolts[15:0], charge_tenths[9:0] valid/ready
// wr_*        in   wr_index[2:0], wr_data[22:0]             wr_en, no stall
//
// an item that does not complete a reading is only added to the sample sum
// an item that completes a reading runs the shared 28-step divider once for the mean,
// for the average step unless the average is seeded, and for interpolation inside the curve
// only one reading is worked on at a time; the result register frees the input side
// the block stalls in its emit step while the previous result is still not taken
// reset: average empty, sample sum and count zero, registers at their defaults
module battery_level_estimator
    import ble_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ble_in_if.sink                sample_in,
    ble_out_if.source             result_out,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);
    cmd_t    cmd;
    status_t sts;

    ble_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ble_datapath #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .wr_en              (wr_en),
        .wr_index           (wr_index),
        .wr_data            (wr_data),
        .sample_millivolts  (sample_in.sample_millivolts),
        .mode_scale         (sample_in.mode_scale),
        .result_valid       (result_out.valid),
        .result_ready       (result_out.ready),
        .average_millivolts (result_out.average_millivolts),
        .charge_tenths      (result_out.charge_tenths)
    );

endmodule

// ===== sim/tb_battery_level_estimator.sv =====
module tb_battery_level_estimator;
    import ble_pkg::*;

    localparam int UNITY_SCALE  = 1 << SCALE_SHIFT;
    localparam int MV_MAX       = (1 << IN_MV_W) - 1;
    localparam int N_POINTS     = (CURVE_POINTS_DEF < NUM_POINT_REGS) ?
                                  CURVE_POINTS_DEF : NUM_POINT_REGS;
    localparam int DRAIN_CYCLES = 120;
    localparam int N_PHASES     = 7;

    typedef struct packed {
        logic [IN_MV_W-1:0] mv;
        logic [SCALE_W-1:0] scale;
    } sample_t;

    typedef struct packed {
        logic [AVG_W-1:0]    avg;
        logic [TENTHS_W-1:0] tenths;
    } reading_t;

    typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;
    typedef enum int {CURVE_DEFAULT, CURVE_ORDERED, CURVE_SHUFFLED, CURVE_EXTREME} curve_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    ble_in_if  sample_in();
    ble_out_if result_out();

    sample_t  pending_samples[$];
    reading_t expected_readings[$];
    sample_t  next_sample;
    logic     in_fire;
    int       send_gap_pct;
    int       recv_stall_pct;
    int       queued_count;
    int       accepted_count;
    int       readings_checked;
    int       writes_done;
    int       mismatches;

    // mirror of the block state and registers
    logic [CNT_CFG_W-1:0] cfg_samples;
    logic [CNT_CFG_W-1:0] cfg_divisor;
    point_t               cfg_point [NUM_POINT_REGS];
    logic [SUM_W-1:0]     acc_sum;
    logic [CNT_CFG_W-1:0] acc_count;
    logic [AVG_W-1:0]     avg_mv;

    battery_level_estimator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .result_out (result_out),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    function automatic logic [TENTHS_W-1:0] charge_from_average(logic [AVG_W-1:0] v);
        int                i;
        longint unsigned   vv;
        longint unsigned   lo_mv;
        longint unsigned   hi_mv;
        longint unsigned   lo_pct;
        longint unsigned   hi_pct;
        longint unsigned   level;
        vv = 64'(v);
        i = 0;
        while (i < N_POINTS && cfg_point[i][AVG_W-1:0] < v)
            i++;
        if (i == 0)
            level = 64'(cfg_point[0][AVG_W +: PCT_W]) * 64'(TENTHS);
        else if (i >= N_POINTS)
            level = 64'(cfg_point[N_POINTS-1][AVG_W +: PCT_W]) * 64'(TENTHS);
        else
        begin
            lo_mv  = 64'(cfg_point[i-1][AVG_W-1:0]);
            hi_mv  = 64'(cfg_point[i][AVG_W-1:0]);
            lo_pct = 64'(cfg_point[i-1][AVG_W +: PCT_W]);
            hi_pct = 64'(cfg_point[i][AVG_W +: PCT_W]);
            level  = (((vv - lo_mv) * hi_pct + (hi_mv - vv) * lo_pct) * 64'(TENTHS))
                     / (hi_mv - lo_mv);
        end
        if (level > 64'(MAX_TENTHS))
            level = 64'(MAX_TENTHS);
        return TENTHS_W'(level);
    endfunction

    function automatic void fold_sample(sample_t s);
        logic [AVG_W-1:0] scaled;
        int unsigned      need;
        int unsigned      div;
        int unsigned      mean;
        int               diff;
        reading_t         r;
        scaled    = AVG_W'((int'(s.mv) * int'(s.scale)) / UNITY_SCALE);
        acc_sum   = acc_sum + SUM_W'(scaled);
        acc_count = acc_count + 1'b1;
        need      = (cfg_samples == 0) ? 1 : 32'(cfg_samples);
        if (acc_count < need)
            return;
        mean      = 32'(acc_sum) / need;
        acc_sum   = '0;
        acc_count = '0;
        if (avg_mv == EMPTY_MARK)
            avg_mv = AVG_W'(mean);
        else
        begin
            div    = (cfg_divisor == 0) ? 1 : 32'(cfg_divisor);
            diff   = int'(mean) - int'(avg_mv);
            avg_mv = AVG_W'(int'(avg_mv) + diff / int'(div));
        end
        r.avg    = avg_mv;
        r.tenths = charge_from_average(avg_mv);
        expected_readings.push_back(r);
    endfunction

    function automatic sample_t shaped_sample(int target);
        sample_t s;
        int      roll;
        int      mv;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            s.scale = SCALE_W'(UNITY_SCALE);
            mv = target + int'($urandom_range(0, 40)) - 20;
        end
        else if (roll < 75)
        begin
            s.scale = SCALE_W'($urandom_range(32, 128));
            mv = target * UNITY_SCALE / int'(s.scale) + int'($urandom_range(0, 20)) - 10;
        end
        else
        begin
            s.scale = SCALE_W'($urandom_range(0, 255));
            mv = $urandom_range(0, MV_MAX);
        end
        if (mv < 0)
            mv = 0;
        if (mv > MV_MAX)
            mv = MV_MAX;
        s.mv = IN_MV_W'(mv);
        return s;
    endfunction

    task automatic push_sample(int mv, int scale);
        pending_samples.push_back({IN_MV_W'(mv), SCALE_W'(scale)});
        queued_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        if (idx == REG_SAMPLES)
            cfg_samples = data[CNT_CFG_W-1:0];
        else if (idx == REG_DIVISOR)
            cfg_divisor = data[CNT_CFG_W-1:0];
        else
            cfg_point[idx - REG_POINT0] = data;
        writes_done++;
    endtask

    task automatic end_writes();
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_curve(curve_style_t style);
        int     mv;
        int     pct;
        point_t p;
        mv  = $urandom_range(2000, 3200);
        pct = $urandom_range(0, 20);
        for (int k = 0; k < NUM_POINT_REGS; k++)
        begin
            case (style)
                CURVE_DEFAULT:  p = POINT_RESET[k];
                CURVE_ORDERED:  p = {PCT_W'(pct), AVG_W'(mv)};
                CURVE_SHUFFLED: p = {PCT_W'($urandom_range(0, 127)),
                                     AVG_W'($urandom_range(0, 4500))};
                default:
                begin
                    if (k == 0)
                        p = '0;
                    else if (k == NUM_POINT_REGS - 1)
                        p = {PCT_W'(101), {AVG_W{1'b1}}};
                    else
                        p = {PCT_W'(pct), AVG_W'(mv)};
                end
            endcase
            write_reg(CFG_IDX_W'(REG_POINT0 + k), p);
            mv  += $urandom_range(50, 300);
            pct += $urandom_range(0, 21);
        end
    endtask

    task automatic wait_for_drain();
        while (accepted_count != queued_count || expected_readings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d readings still expected", expected_readings.size());
        $display("Some tests failed");
        $finish;
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_in.valid  <= 1'b0;
            result_out.ready <= 1'b0;
        end
        else
        begin
            if (!sample_in.valid || in_fire)
            begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    next_sample = pending_samples.pop_front();
                    sample_in.valid             <= 1'b1;
                    sample_in.sample_millivolts <= next_sample.mv;
                    sample_in.mode_scale        <= next_sample.scale;
                end
                else
                    sample_in.valid <= 1'b0;
            end
            result_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= sample_in.valid && sample_in.ready;
            if (sample_in.valid && sample_in.ready)
            begin
                accepted_count++;
                fold_sample({sample_in.sample_millivolts, sample_in.mode_scale});
            end
            if (result_out.valid && result_out.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result with nothing expected: average_millivolts %0d",
                           result_out.average_millivolts);
                    mismatches++;
                end
                else
                begin
                    reading_t want;
                    want = expected_readings.pop_front();
                    readings_checked++;
                    if (result_out.average_millivolts !== want.avg)
                    begin
                        $error("average_millivolts: expected %0d, actual %0d",
                               want.avg, result_out.average_millivolts);
                        mismatches++;
                    end
                    if (result_out.charge_tenths !== want.tenths)
                    begin
                        $error("charge_tenths: expected %0d, actual %0d",
                               want.tenths, result_out.charge_tenths);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        int           cnt;
        int           dv;
        int           readings;
        int           target;
        int           k;
        curve_style_t style;

        rst_n                       = 1'b0;
        wr_en                       = 1'b0;
        wr_index                    = '0;
        wr_data                     = '0;
        sample_in.valid             = 1'b0;
        sample_in.sample_millivolts = '0;
        sample_in.mode_scale        = '0;
        result_out.ready            = 1'b0;
        in_fire                     = 1'b0;
        send_gap_pct                = 0;
        recv_stall_pct              = 0;
        queued_count                = 0;
        accepted_count              = 0;
        readings_checked            = 0;
        writes_done                 = 0;
        mismatches                  = 0;
        cfg_samples                 = SAMPLES_RESET;
        cfg_divisor                 = DIVISOR_RESET;
        for (int i = 0; i < NUM_POINT_REGS; i++)
            cfg_point[i] = POINT_RESET[i];
        acc_sum   = '0;
        acc_count = '0;
        avg_mv    = EMPTY_MARK;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // field extremes on the reset settings, first reading seeds the average
        push_sample(MV_MAX, 255);
        push_sample(0, 0);
        push_sample(MV_MAX, UNITY_SCALE);
        push_sample(0, 255);
        push_sample(2048, 128);
        push_sample(1, 1);
        push_sample(MV_MAX, 0);
        push_sample(3300, UNITY_SCALE);
        wait_for_drain();

        // zero count and zero divisor, below, on and above the curve
        write_reg(REG_SAMPLES, '0);
        write_reg(REG_DIVISOR, '0);
        end_writes();
        push_sample(3000, UNITY_SCALE);
        push_sample(3750, UNITY_SCALE);
        push_sample(MV_MAX, 80);
        wait_for_drain();

        // count lowered while a reading is partly done
        write_reg(REG_SAMPLES, CFG_DATA_W'(4));
        write_reg(REG_DIVISOR, CFG_DATA_W'(255));
        end_writes();
        push_sample(3600, UNITY_SCALE);
        push_sample(3600, UNITY_SCALE);
        push_sample(3600, UNITY_SCALE);
        wait_for_drain();
        write_reg(REG_SAMPLES, CFG_DATA_W'(2));
        end_writes();
        push_sample(3600, UNITY_SCALE);
        wait_for_drain();

        // unordered points and percent above 100
        write_reg(REG_SAMPLES, CFG_DATA_W'(1));
        write_reg(REG_DIVISOR, CFG_DATA_W'(1));
        write_reg(CFG_IDX_W'(REG_POINT0 + 0), {PCT_W'(50), AVG_W'(3500)});
        write_reg(CFG_IDX_W'(REG_POINT0 + 1), {PCT_W'(127), AVG_W'(3400)});
        write_reg(CFG_IDX_W'(REG_POINT0 + 2), {PCT_W'(120), AVG_W'(3900)});
        write_reg(CFG_IDX_W'(REG_POINT0 + 3), {PCT_W'(0), AVG_W'(3600)});
        write_reg(CFG_IDX_W'(REG_POINT0 + 4), {PCT_W'(127), AVG_W'(4000)});
        write_reg(CFG_IDX_W'(REG_POINT0 + 5), {PCT_W'(3), AVG_W'(3000)});
        end_writes();
        push_sample(3450, UNITY_SCALE);
        push_sample(3700, UNITY_SCALE);
        push_sample(3950, UNITY_SCALE);
        push_sample(4050, UNITY_SCALE);
        wait_for_drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:       begin cnt = 1;   dv = 1;   readings = 60; style = CURVE_DEFAULT;  end
                1:       begin cnt = 255; dv = 255; readings = 1;  style = CURVE_ORDERED;  end
                2:       begin cnt = 3;   dv = 2;   readings = 30; style = CURVE_SHUFFLED; end
                3:       begin cnt = 1;   dv = 7;   readings = 60; style = CURVE_ORDERED;  end
                4:       begin cnt = 2;   dv = 0;   readings = 40; style = CURVE_SHUFFLED; end
                5:       begin cnt = 5;   dv = 3;   readings = 20; style = CURVE_ORDERED;  end
                default: begin cnt = 1;   dv = 128; readings = 40; style = CURVE_EXTREME;  end
            endcase
            case (pace_t'(ph % 4))
                PACE_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                PACE_SEND_GAPS:   begin send_gap_pct = 88; recv_stall_pct = 0;  end
                PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 88; end
                default:          begin send_gap_pct = 29; recv_stall_pct = 29; end
            endcase
            write_reg(REG_SAMPLES, CFG_DATA_W'(cnt));
            write_reg(REG_DIVISOR, CFG_DATA_W'(dv));
            load_curve(style);
            end_writes();
            for (int r = 0; r < readings; r++)
            begin
                k = $urandom_range(0, N_POINTS - 1);
                target = int'(cfg_point[k][AVG_W-1:0]) + int'($urandom_range(0, 400)) - 200;
                if (target < 0)
                    target = 0;
                if (target > 8000)
                    target = 8000;
                for (int s = 0; s < cnt; s++)
                    push_sample_item: pending_samples.push_back(shaped_sample(target));
                queued_count += cnt;
                // in phase 2, after every tenth reading the sender holds off until every pending reading is out
                if (ph == 2 && r % 10 == 9)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        $display("checked %0d readings from %0d samples after %0d register writes",
                 readings_checked, accepted_count, writes_done);
        $display("covered zero and full counts, divisors 1 to 255, shuffled and extreme curves");
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
